// ===== sv/q2e_pkg.sv =====
// Package for the quaternion to Euler angle converter.
// Holds widths, the CORDIC arctangent table and shared helper functions.
// No dependencies.
package q2e_pkg;

   localparam int DataBits    = 16;
   localparam int Frac        = DataBits - 1;
   localparam int CordicSteps = 16;
   localparam int TermW       = DataBits + 1;
   localparam int CordW       = TermW + 3;
   localparam int SqW         = 2 * TermW;
   localparam int RootW       = TermW;

   typedef logic signed [TermW-1:0] term_type;
   typedef logic signed [CordW-1:0] cord_type;

   localparam logic [31:0] ATAN_TAB [0:31] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
      32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
      32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
      32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0};

   // Round a Q2.30 product sum to Q.Frac half up and saturate to [-1, 1].
   function automatic term_type to_term(input logic signed [35:0] e);
      logic signed [35:0] r;
      logic signed [35:0] one;
      begin
         r   = (e + (36'sd1 <<< (29 - Frac))) >>> (30 - Frac);
         one = 36'sd1 <<< Frac;
         if (r > one) begin
            r = one;
         end else if (r < -one) begin
            r = -one;
         end
         to_term = r[TermW-1:0];
      end
   endfunction

   // Round a 32-bit angle accumulator to a 16-bit binary angle.
   function automatic logic [15:0] round_angle(input logic [31:0] z);
      logic [31:0] t;
      begin
         t = z + 32'h0000_8000;
         round_angle = t[31:16];
      end
   endfunction

endpackage

// ===== sv/q2e_matrix.sv =====
// Rotation matrix terms from a quaternion, two register stages.
// Depends on q2e_pkg.
module q2e_matrix import q2e_pkg::*; (
   input  logic                clock,
   input  logic                enable,
   input  logic signed [15:0]  quat_x,
   input  logic signed [15:0]  quat_y,
   input  logic signed [15:0]  quat_z,
   input  logic signed [15:0]  quat_w,
   output term_type            m11,
   output term_type            m12,
   output term_type            m21,
   output term_type            m22,
   output term_type            m31,
   output term_type            m32,
   output term_type            m33
);

   logic signed [31:0] xx_ff, yy_ff, zz_ff, xy_ff, zw_ff, xz_ff, yw_ff, yz_ff, xw_ff;
   term_type m11_ff, m12_ff, m21_ff, m22_ff, m31_ff, m32_ff, m33_ff;
   localparam logic signed [35:0] One30 = 36'sd1 <<< 30;

   // First stage: the nine products.
   always_ff @(posedge clock) begin
      if (enable) begin
         xx_ff <= quat_x * quat_x;
         yy_ff <= quat_y * quat_y;
         zz_ff <= quat_z * quat_z;
         xy_ff <= quat_x * quat_y;
         zw_ff <= quat_z * quat_w;
         xz_ff <= quat_x * quat_z;
         yw_ff <= quat_y * quat_w;
         yz_ff <= quat_y * quat_z;
         xw_ff <= quat_x * quat_w;
      end
   end

   // Second stage: sums, rounding and saturation.
   always_ff @(posedge clock) begin
      if (enable) begin
         m11_ff <= to_term(One30 - 36'sd2 * (36'(yy_ff) + 36'(zz_ff)));
         m12_ff <= to_term(36'sd2 * (36'(xy_ff) + 36'(zw_ff)));
         m21_ff <= to_term(36'sd2 * (36'(xy_ff) - 36'(zw_ff)));
         m22_ff <= to_term(One30 - 36'sd2 * (36'(xx_ff) + 36'(zz_ff)));
         m31_ff <= to_term(36'sd2 * (36'(xz_ff) + 36'(yw_ff)));
         m32_ff <= to_term(36'sd2 * (36'(yz_ff) - 36'(xw_ff)));
         m33_ff <= to_term(One30 - 36'sd2 * (36'(xx_ff) + 36'(yy_ff)));
      end
   end

   assign m11 = m11_ff;
   assign m12 = m12_ff;
   assign m21 = m21_ff;
   assign m22 = m22_ff;
   assign m31 = m31_ff;
   assign m32 = m32_ff;
   assign m33 = m33_ff;

endmodule

// ===== sv/q2e_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
// Depends on q2e_pkg.
module q2e_sqrt import q2e_pkg::*; (
   input  logic             clock,
   input  logic             enable,
   input  logic [SqW-1:0]   radicand,
   output logic [RootW-1:0] root
);

   localparam int Steps = SqW / 2;

   logic [SqW-1:0]   rem_ff  [0:Steps];
   logic [SqW-1:0]   res_ff  [0:Steps];
   logic [SqW-1:0]   rem_in  [1:Steps];
   logic [SqW-1:0]   res_in  [1:Steps];

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff[0] <= radicand;
         res_ff[0] <= '0;
      end
   end

   // Each stage tries the bit 4^(Steps-k) as in the classic digit method.
   for (genvar k = 1; k <= Steps; k++) begin : g_step
      localparam logic [SqW-1:0] Bit = {{(SqW-1){1'b0}}, 1'b1} << (2 * (Steps - k));
      always_comb begin
         if (rem_ff[k-1] >= res_ff[k-1] + Bit) begin
            rem_in[k] = rem_ff[k-1] - (res_ff[k-1] + Bit);
            res_in[k] = (res_ff[k-1] >> 1) + Bit;
         end else begin
            rem_in[k] = rem_ff[k-1];
            res_in[k] = res_ff[k-1] >> 1;
         end
      end
      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[k] <= rem_in[k];
            res_ff[k] <= res_in[k];
         end
      end
   end

   assign root = res_ff[Steps][RootW-1:0];

endmodule

// ===== sv/q2e_cordic.sv =====
// Pipelined CORDIC vectoring atan2 with quadrant pre-rotation.
// Depends on q2e_pkg.
module q2e_cordic import q2e_pkg::*; (
   input  logic        clock,
   input  logic        enable,
   input  cord_type    y_val,
   input  cord_type    x_val,
   output logic [15:0] angle
);

   cord_type    x_ff [0:CordicSteps];
   cord_type    y_ff [0:CordicSteps];
   logic [31:0] z_ff [0:CordicSteps];
   logic        zero_ff [0:CordicSteps];

   // Pre-rotation of the left half plane by plus or minus pi/2.
   always_ff @(posedge clock) begin
      if (enable) begin
         zero_ff[0] <= (x_val == '0) && (y_val == '0);
         if (x_val < 0) begin
            if (y_val >= 0) begin
               x_ff[0] <= y_val;
               y_ff[0] <= -x_val;
               z_ff[0] <= 32'h4000_0000;
            end else begin
               x_ff[0] <= -y_val;
               y_ff[0] <= x_val;
               z_ff[0] <= 32'hC000_0000;
            end
         end else begin
            x_ff[0] <= x_val;
            y_ff[0] <= y_val;
            z_ff[0] <= '0;
         end
      end
   end

   // One micro-rotation per stage.
   for (genvar i = 0; i < CordicSteps; i++) begin : g_rot
      always_ff @(posedge clock) begin
         if (enable) begin
            zero_ff[i+1] <= zero_ff[i];
            if (y_ff[i] >= 0) begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + ATAN_TAB[i];
            end else begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - ATAN_TAB[i];
            end
         end
      end
   end

   assign angle = zero_ff[CordicSteps] ? 16'd0 : round_angle(z_ff[CordicSteps]);

endmodule

// ===== sv/quaternion_to_euler_unit.sv =====
// Quaternion to Euler angle converter, top level.
// Pipeline order: matrix terms, square root, CORDIC angles, then the result register.
// Throughput: one quaternion per cycle; the whole pipe advances when the
// result register is free or being drained, so a stall holds every stage.
// Reset: synchronous, active high; clears valid bits, threshold returns to 1.
// Depends on q2e_pkg, q2e_matrix, q2e_sqrt and q2e_cordic.
module quaternion_to_euler_unit import q2e_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [14:0] csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // quat_x, quat_y, quat_z, quat_w
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // pitch_angle, yaw_angle, roll_angle
   output logic        rsp_tuser    // gimbal_locked
);

   localparam int SqrtLat = SqW / 2 + 1;
   localparam int Depth   = 2 + SqrtLat + CordicSteps + 1;

   logic [14:0] thresh_ff;
   logic        adv;
   logic [Depth-1:0] vld_ff;
   logic        out_vld_ff;
   logic [47:0] out_data_ff;
   logic        out_lock_ff;

   term_type m11, m12, m21, m22, m31, m32, m33;
   logic [RootW-1:0] root;
   logic [SqW-1:0]   sq;

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= 15'd1;
      end else if (csr_we) begin
         thresh_ff <= csr_wdata;
      end
   end

   assign adv        = !out_vld_ff || rsp_tready;
   assign req_tready = adv;

   // Valid bits travel alongside the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[Depth-2:0], req_tvalid};
      end
   end

   q2e_matrix u_matrix (
      .clock(clock), .enable(adv),
      .quat_x(req_tdata[15:0]), .quat_y(req_tdata[31:16]),
      .quat_z(req_tdata[47:32]), .quat_w(req_tdata[63:48]),
      .m11(m11), .m12(m12), .m21(m21), .m22(m22), .m31(m31), .m32(m32), .m33(m33)
   );

   // Terms are at most 2^15 in magnitude, so the sum of squares fits.
   assign sq = SqW'(unsigned'(SqW'(m31 * m31))) + SqW'(unsigned'(SqW'(m33 * m33)));

   q2e_sqrt u_sqrt (.clock(clock), .enable(adv), .radicand(sq), .root(root));

   // Delay the matrix terms to line up with the root.
   term_type d12 [0:SqrtLat-1], d22 [0:SqrtLat-1], d21 [0:SqrtLat-1];
   term_type d11 [0:SqrtLat-1], d31 [0:SqrtLat-1], d32 [0:SqrtLat-1];
   term_type d33 [0:SqrtLat-1];
   always_ff @(posedge clock) begin
      if (adv) begin
         d11[0] <= m11; d12[0] <= m12; d21[0] <= m21; d22[0] <= m22;
         d31[0] <= m31; d32[0] <= m32; d33[0] <= m33;
         for (int k = 1; k < SqrtLat; k++) begin
            d11[k] <= d11[k-1]; d12[k] <= d12[k-1]; d21[k] <= d21[k-1];
            d22[k] <= d22[k-1]; d31[k] <= d31[k-1]; d32[k] <= d32[k-1];
            d33[k] <= d33[k-1];
         end
      end
   end

   // Gimbal lock decision: root * 2^15 <= threshold * 2^Frac.
   logic lock_now;
   logic [47:0] lhs, rhs;
   assign lhs = 48'(root) << 15;
   assign rhs = 48'(thresh_ff) << Frac;
   assign lock_now = lhs <= rhs;

   cord_type py, px, yy, yx, ry, rx;
   assign py = -CordW'(d32[SqrtLat-1]);
   assign px = CordW'(signed'({1'b0, root}));
   assign yy = CordW'(d31[SqrtLat-1]);
   assign yx = CordW'(d33[SqrtLat-1]);
   assign ry = lock_now ? -CordW'(d21[SqrtLat-1]) : CordW'(d12[SqrtLat-1]);
   assign rx = lock_now ? CordW'(d11[SqrtLat-1]) : CordW'(d22[SqrtLat-1]);

   logic lock_d [0:CordicSteps];
   always_ff @(posedge clock) begin
      if (adv) begin
         lock_d[0] <= lock_now;
         for (int k = 1; k <= CordicSteps; k++) begin
            lock_d[k] <= lock_d[k-1];
         end
      end
   end

   logic [15:0] pa, ya, ra;
   q2e_cordic u_pitch (.clock(clock), .enable(adv), .y_val(py), .x_val(px), .angle(pa));
   q2e_cordic u_yaw   (.clock(clock), .enable(adv), .y_val(yy), .x_val(yx), .angle(ya));
   q2e_cordic u_roll  (.clock(clock), .enable(adv), .y_val(ry), .x_val(rx), .angle(ra));

   // Clamp pitch to a quarter turn each way.
   logic [15:0] pclamp;
   always_comb begin
      if ($signed(pa) > 16'sd16384) begin
         pclamp = 16'd16384;
      end else if ($signed(pa) < -16'sd16384) begin
         pclamp = 16'hC000;
      end else begin
         pclamp = pa;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         out_vld_ff <= vld_ff[Depth-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_data_ff <= {ra, lock_d[CordicSteps] ? 16'd0 : ya, pclamp};
         out_lock_ff <= lock_d[CordicSteps];
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_lock_ff;

endmodule
